// ===== design/cua_pkg.sv =====
// ----------------------------------------------------------------------------
// cua_pkg: shared types and constants for the contiguous unit allocator
// Request codes, fit policies, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package cua_pkg;

  localparam int MapUnitsDefault = 4096;
  localparam int IndexW = 12;
  localparam int MarkW  = 8;
  localparam int SizeW  = 13;
  localparam int FailW  = 16;

  localparam logic [MarkW-1:0] MarkFree  = 8'hFF;
  localparam logic [MarkW-1:0] MarkTaken = 8'h00;
  localparam logic [FailW-1:0] FailMax   = 16'hFFFF;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_ALLOC   = 2'd1,
    REQ_COMPACT = 2'd2,
    REQ_READ    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_NEXT  = 2'd1,
    POL_BEST  = 2'd2,
    POL_WORST = 2'd3
  } policy_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_MARK,
    ST_COUNT,
    ST_FILL,
    ST_DONE
  } state_t;

  // map memory access from the sequencer
  typedef struct packed {
    logic                rd_en;
    logic [15:0]         rd_addr;
    logic                wr_en;
    logic [15:0]         wr_addr;
    logic [MarkW-1:0]    wr_data;
  } mem_req_t;

endpackage

// ===== design/cua_if.sv =====
// ----------------------------------------------------------------------------
// cua_if: valid/ready channel interfaces
// Request, result and configuration word channels.
// ----------------------------------------------------------------------------
interface cua_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [11:0] unit_index;
  logic [7:0]  unit_mark;
  logic [12:0] alloc_size;
  modport source (output valid, req_type, unit_index, unit_mark, alloc_size,
                  input ready);
  modport sink   (input valid, req_type, unit_index, unit_mark, alloc_size,
                  output ready);
endinterface

interface cua_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [11:0] alloc_start;
  logic [7:0]  read_mark;
  logic [15:0] failure_count;
  modport source (output valid, status, alloc_start, read_mark, failure_count,
                  input ready);
  modport sink   (input valid, status, alloc_start, read_mark, failure_count,
                  output ready);
endinterface

interface cua_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== design/cua_map_ram.sv =====
// ----------------------------------------------------------------------------
// cua_map_ram: unit mark memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cua_map_ram #(
  parameter int Depth = cua_pkg::MapUnitsDefault,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                    clk,
  input  cua_pkg::mem_req_t       req,
  output logic [cua_pkg::MarkW-1:0] rd_data
);
  import cua_pkg::*;

  logic [MarkW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AddrW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr[AddrW-1:0]];
    end
  end
endmodule

// ===== design/cua_seq.sv =====
// ----------------------------------------------------------------------------
// cua_seq: request sequencer
// Walks the map for scans, marking and compaction; builds the result word.
// ----------------------------------------------------------------------------
module cua_seq #(
  parameter int MapUnits = cua_pkg::MapUnitsDefault,
  parameter int AddrW = $clog2(MapUnits)
) (
  input  logic                clk,
  input  logic                rst,
  cua_req_if.sink             rq,
  cua_rsp_if.source           rs,
  cua_cfg_if.sink             cf,
  output cua_pkg::mem_req_t   mreq,
  input  logic [cua_pkg::MarkW-1:0] rd_data
);
  import cua_pkg::*;

  localparam int CntW = AddrW + 1;
  localparam int SumW = CntW + 1;
  localparam logic [CntW-1:0] Units = CntW'(MapUnits);

  state_t state, state_next;
  logic [1:0] policy;

  logic [11:0]      idx;
  logic [12:0]      size;

  // scan position p (0..MapUnits); the read data for step p arrives in the cycle after its address is issued
  logic [CntW-1:0]  p, p_next;
  logic [AddrW-1:0] base;
  logic [AddrW-1:0] nf_start;
  logic [AddrW-1:0] run_start;
  logic [CntW-1:0]  run_len;
  logic             found;
  logic [AddrW-1:0] best_start;
  logic [CntW-1:0]  best_len;
  logic [CntW-1:0]  zeros;
  logic [CntW-1:0]  mcnt;
  logic [AddrW-1:0] maddr;
  logic [FailW-1:0] failures;

  logic             o_status;
  logic [11:0]      o_start;
  logic [7:0]       o_mark;

  logic             in_map;
  logic [AddrW-1:0] upos;
  logic             is_free;
  logic             big;
  logic             take;
  logic             early;
  logic             out_free;

  // unit index plus offset, wrapped at the map size
  function automatic logic [AddrW-1:0] wrap_add(input logic [AddrW-1:0] a,
                                                input logic [CntW-1:0]  b);
    logic [SumW-1:0] sum;
    sum = {2'b00, a} + {1'b0, b};
    if (sum >= SumW'(MapUnits)) begin
      sum = sum - SumW'(MapUnits);
    end
    return sum[AddrW-1:0];
  endfunction

  assign in_map = (32'(idx) < 32'(MapUnits));
  assign upos   = wrap_add(base, p);
  assign is_free = (p < Units) && (rd_data == MarkFree);
  assign big    = (run_len != '0) && (32'(run_len) >= 32'(size));
  assign early  = (policy == POL_FIRST) || (policy == POL_NEXT);
  assign take   = big && (!found || (policy == POL_BEST && run_len < best_len) ||
                          (policy == POL_WORST && run_len > best_len));
  assign out_free = !rs.valid || rs.ready;

  assign rq.ready = (state == ST_IDLE);
  assign cf.ready = (state == ST_IDLE) && !rq.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      policy   <= POL_FIRST;
      nf_start <= '0;
      failures <= '0;
      rs.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cf.valid && cf.ready) begin
        policy <= cf.data;
      end
      if (state == ST_DONE && out_free) begin
        rs.valid <= 1'b1;
      end else if (rs.valid && rs.ready) begin
        rs.valid <= 1'b0;
      end
      if (state == ST_SCAN && !is_free && big && early) begin
        if (policy == POL_NEXT) begin
          nf_start <= wrap_add(run_start, CntW'(size));
        end
      end else if (state == ST_SCAN && p == Units) begin
        if (!(found || take) && failures != FailMax) begin
          failures <= failures + 1'b1;
        end
      end else if (state == ST_IDLE && rq.valid && rq.req_type == REQ_ALLOC &&
                   rq.alloc_size == '0 && failures != FailMax) begin
        failures <= failures + 1'b1;
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (rq.valid) begin
          idx  <= rq.unit_index;
          size <= rq.alloc_size;
          p    <= '0;
          run_len <= '0;
          found   <= 1'b0;
          best_len <= '0;
          best_start <= '0;
          zeros <= '0;
          o_status <= (rq.req_type == REQ_ALLOC) && (rq.alloc_size == '0);
          o_start  <= '0;
          o_mark   <= '0;
          base <= (policy == POL_NEXT) ? nf_start : '0;
        end
      end
      ST_READ: begin
        o_mark <= in_map ? rd_data : '0;
      end
      ST_SCAN: begin
        p <= p_next;
        if (is_free) begin
          if (run_len == '0) begin
            run_start <= upos;
          end
          run_len <= run_len + 1'b1;
        end else begin
          if (big && early) begin
            found <= 1'b1;
            best_start <= run_start;
            best_len <= run_len;
          end else if (take) begin
            found <= 1'b1;
            best_start <= run_start;
            best_len <= run_len;
          end
          run_len <= '0;
        end
        if (p == Units) begin
          mcnt  <= '0;
          maddr <= (take || (big && early)) ? run_start : best_start;
          o_status <= !(found || take || (big && early));
          o_start  <= (found || take || (big && early)) ?
                      12'((take || (big && early)) ? run_start : best_start) : '0;
        end else if (!is_free && big && early) begin
          mcnt  <= '0;
          maddr <= run_start;
          o_start <= 12'(run_start);
        end
      end
      ST_MARK: begin
        mcnt  <= mcnt + 1'b1;
        maddr <= wrap_add(maddr, CntW'(1));
      end
      ST_COUNT: begin
        p <= p + 1'b1;
        if (rd_data == MarkTaken) begin
          zeros <= zeros + 1'b1;
        end
        if (p == Units - 1'b1) begin
          mcnt <= '0;
        end
      end
      ST_FILL: begin
        mcnt <= mcnt + 1'b1;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    p_next = p + 1'b1;
    mreq = '0;
    unique case (state)
      ST_IDLE: begin
        if (rq.valid) begin
          unique case (rq.req_type)
            REQ_LOAD: begin
              mreq.wr_en   = (32'(rq.unit_index) < 32'(MapUnits));
              mreq.wr_addr = 16'(rq.unit_index);
              mreq.wr_data = rq.unit_mark;
              state_next   = ST_DONE;
            end
            REQ_READ: begin
              mreq.rd_en   = 1'b1;
              mreq.rd_addr = 16'(rq.unit_index[AddrW-1 < 11 ? AddrW-1 : 11:0]);
              state_next   = ST_READ;
            end
            REQ_COMPACT: begin
              mreq.rd_en = 1'b1;
              state_next = ST_COUNT;
            end
            default: begin
              mreq.rd_en   = (rq.alloc_size != '0);
              mreq.rd_addr = 16'((policy == POL_NEXT) ? nf_start : '0);
              state_next   = (rq.alloc_size != '0) ? ST_SCAN : ST_DONE;
            end
          endcase
        end
      end
      ST_READ: state_next = ST_DONE;
      ST_SCAN: begin
        mreq.rd_en   = (p_next < Units);
        mreq.rd_addr = 16'(wrap_add(base, p_next));
        if (!is_free && big && early) begin
          state_next = ST_MARK;
        end else if (p == Units) begin
          state_next = (found || take) ? ST_MARK : ST_DONE;
        end
      end
      ST_MARK: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = 16'(maddr);
        mreq.wr_data = MarkTaken;
        if (32'(mcnt) == 32'(size) - 32'd1) begin
          state_next = ST_DONE;
        end
      end
      ST_COUNT: begin
        mreq.rd_en   = (p_next < Units);
        mreq.rd_addr = 16'(p_next);
        if (p == Units - 1'b1) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = 16'(mcnt);
        mreq.wr_data = (mcnt < zeros) ? MarkTaken : MarkFree;
        if (mcnt == Units - 1'b1) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // result word: load only when the output slot is free, hold it otherwise
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      rs.status        <= o_status;
      rs.alloc_start   <= o_start;
      rs.read_mark     <= o_mark;
      rs.failure_count <= failures;
    end
  end
endmodule

// ===== design/contiguous_unit_allocator.sv =====
// ----------------------------------------------------------------------------
// contiguous_unit_allocator: top level
// Unit map in one synchronous RAM, driven by a scan/mark sequencer.
// ----------------------------------------------------------------------------
// One request is in flight at a time; the map RAM port is walked one unit
// per cycle during scans, marking and compaction.
// Reset: policy first fit, next-fit pointer and failure count zero; the map
// itself is not cleared and must be loaded before use.
module contiguous_unit_allocator #(
  parameter int MAP_UNITS = cua_pkg::MapUnitsDefault
) (
  input  logic      clk,
  input  logic      rst,
  cua_req_if.sink   req,
  cua_rsp_if.source rsp,
  cua_cfg_if.sink   cfg
);
  import cua_pkg::*;

  mem_req_t         mreq;
  logic [MarkW-1:0] rd_data;

  // sequencer: owns all three handshakes and all scan state
  cua_seq #(.MapUnits(MAP_UNITS)) u_seq (
    .clk, .rst, .rq(req), .rs(rsp), .cf(cfg), .mreq, .rd_data
  );

  // mark storage, one access of each kind per cycle
  cua_map_ram #(.Depth(MAP_UNITS)) u_ram (
    .clk, .req(mreq), .rd_data
  );
endmodule

// ===== design/cua_checker.sv =====
// ----------------------------------------------------------------------------
// cua_checker: port-level checks
// Result handshake and counter behavior seen at the top level.
// ----------------------------------------------------------------------------
module cua_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_status,
  input logic [11:0] rsp_start,
  input logic [15:0] rsp_fail
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
  a_fail_start: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status |-> rsp_start == 12'd0) else $error("start on fail");
  a_fail_cnt: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status |-> rsp_fail != 16'd0) else $error("count missed");
endmodule

bind contiguous_unit_allocator cua_checker u_chk (
  .clk, .rst, .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_status(rsp.status), .rsp_start(rsp.alloc_start),
  .rsp_fail(rsp.failure_count)
);
